// ===== design/vfdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// vfdcd_pkg
// Types and constants shared by the serial command decoder of a VFD controller.
// ----------------------------------------------------------------------------
package vfdcd_pkg;

    localparam int RAM_DEPTH   = 16;
    localparam int ADDR_W      = 4;
    localparam int RAM_IDX_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam logic [ADDR_W:0] ADDR_LIMIT = (ADDR_W + 1)'(RAM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_MODE    = 2'b00;
    localparam logic [1:0] KIND_DATASET = 2'b01;
    localparam logic [1:0] KIND_DISPCTL = 2'b10;
    localparam logic [1:0] KIND_ADDRSET = 2'b11;

    typedef struct packed {
        logic       func;
        logic       frame_start;
        logic [7:0] byte_value;
        logic [3:0] read_address;
    } in_word_t;

    typedef struct packed {
        logic [7:0] ram_data;
        logic       ram_written;
        logic       disp_enable;
        logic [2:0] dimming;
        logic [1:0] display_mode;
        logic       test_mode;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_MODE,
        OP_DATASET,
        OP_DISPCTL,
        OP_ADDRSET,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/vfd_controller_command_decoder_core.sv =====
// ----------------------------------------------------------------------------
// vfd_controller_command_decoder_core
// Device-side serial command decoder of a vacuum-fluorescent display controller.
// ----------------------------------------------------------------------------
// Input channel: a word is taken at a clock edge with push high and full low.
// Each word is a received serial byte (with its frame-start mark) or a read
// of one display RAM entry. Result channel: while empty is low the oldest
// result word is on result; it is taken at an edge with pop high.
// Exactly one result word per input word, in order.
// A word taken is first held in the operation queue; its result is then written
// into the result queue, from which it can be popped. Throughput: one word per
// cycle while the result queue has room; the back end decodes each operation and does its RAM write as it takes it.
// A two-entry operation queue parts front and back; a two-entry result queue
// parts the back end from the receiver. When the receiver stalls, the result
// queue fills, then the operation queue, then full rises.
// Reset: all control registers and the display RAM clear at once; display
// off, increment addressing, no data frame open. No clearing pass.
// ----------------------------------------------------------------------------
module vfd_controller_command_decoder_core
    import vfdcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    input  logic      pop,
    output logic      empty,
    output out_word_t result
);

    q_status_t q_status;
    logic      q_push, q_pop;
    cmd_t      q_wr_cmd, q_rd_cmd;

    vfdcd_front u_front (
        .push     (push),
        .full     (full),
        .item     (item),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_wr_cmd)
    );

    vfdcd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_wr_cmd),
        .rd_en  (q_pop),
        .rd_cmd (q_rd_cmd),
        .status (q_status)
    );

    vfdcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (q_rd_cmd),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// ===== design/vfdcd_front.sv =====
// ----------------------------------------------------------------------------
// vfdcd_front
// Accepts input words and classifies them into decoded operations.
// ----------------------------------------------------------------------------
module vfdcd_front
    import vfdcd_pkg::*;
(
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    input  q_status_t q_status,
    output logic      q_push,
    output cmd_t      q_cmd
);

    assign full   = q_status.full;
    assign q_push = push && !q_status.full;

    always_comb
    begin
        q_cmd.arg = item.byte_value;
        q_cmd.op  = OP_DATA;
        if (item.func)
        begin
            q_cmd.op  = OP_READ;
            q_cmd.arg = {4'b0000, item.read_address};
        end
        else if (item.frame_start)
        begin
            case (item.byte_value[7:6])
                KIND_MODE:    q_cmd.op = OP_MODE;
                KIND_DATASET: q_cmd.op = OP_DATASET;
                KIND_DISPCTL: q_cmd.op = OP_DISPCTL;
                KIND_ADDRSET: q_cmd.op = OP_ADDRSET;
                default:      q_cmd.op = OP_MODE;
            endcase
        end
    end

endmodule

// ===== design/vfdcd_queue.sv =====
// ----------------------------------------------------------------------------
// vfdcd_queue
// Short queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module vfdcd_queue
    import vfdcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_cmd,
    input  logic      rd_en,
    output cmd_t      rd_cmd,
    output q_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("cmd queue count overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("cmd queue count lost a write");

endmodule

// ===== design/vfdcd_back.sv =====
// ----------------------------------------------------------------------------
// vfdcd_back
// Executes decoded operations: controller state, display RAM, result queue.
// ----------------------------------------------------------------------------
module vfdcd_back
    import vfdcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      q_cmd,
    input  q_status_t q_status,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_word_t result
);

    logic [7:0]        ram_reg [RAM_DEPTH];
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              fixed_reg, fixed_next;
    logic              frame_reg, frame_next;
    logic [1:0]        mode_reg, mode_next;
    logic              test_reg, test_next;
    logic              enable_reg, enable_next;
    logic [2:0]        dim_reg, dim_next;

    out_word_t         res_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] res_wr_reg, res_wr_next;
    logic [QPTR_W-1:0] res_rd_reg, res_rd_next;
    logic [QCNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic              res_full, take, do_pop, ram_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              written;
    out_word_t         res_word;

    assign res_full = (res_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign take     = !q_status.empty && !res_full;
    assign q_pop    = take;
    assign do_pop   = pop && !empty;
    assign result   = res_reg[res_rd_reg];
    assign rd_addr  = q_cmd.arg[ADDR_W-1:0];

    always_comb
    begin
        ptr_next    = ptr_reg;
        fixed_next  = fixed_reg;
        frame_next  = frame_reg;
        mode_next   = mode_reg;
        test_next   = test_reg;
        enable_next = enable_reg;
        dim_next    = dim_reg;
        ram_we      = 1'b0;
        written     = 1'b0;
        rd_data     = 8'h00;
        if (take)
        begin
            case (q_cmd.op)
                OP_READ:
                begin
                    if ({1'b0, rd_addr} < ADDR_LIMIT)
                        rd_data = ram_reg[rd_addr[RAM_IDX_W-1:0]];
                end
                OP_MODE:
                begin
                    mode_next  = q_cmd.arg[1:0];
                    frame_next = 1'b0;
                end
                OP_DATASET:
                begin
                    test_next  = q_cmd.arg[3];
                    fixed_next = q_cmd.arg[2];
                    frame_next = 1'b0;
                end
                OP_DISPCTL:
                begin
                    enable_next = q_cmd.arg[3];
                    dim_next    = q_cmd.arg[2:0];
                    frame_next  = 1'b0;
                end
                OP_ADDRSET:
                begin
                    ptr_next   = q_cmd.arg[ADDR_W-1:0];
                    frame_next = 1'b1;
                end
                OP_DATA:
                begin
                    if (frame_reg)
                    begin
                        if ({1'b0, ptr_reg} < ADDR_LIMIT)
                        begin
                            ram_we  = 1'b1;
                            written = 1'b1;
                        end
                        if (!fixed_reg)
                        begin
                            if (({1'b0, ptr_reg} + 1'b1) >= ADDR_LIMIT)
                                ptr_next = '0;
                            else
                                ptr_next = ptr_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_word.ram_data     = rd_data;
        res_word.ram_written  = written;
        res_word.disp_enable  = enable_next;
        res_word.dimming      = dim_next;
        res_word.display_mode = mode_next;
        res_word.test_mode    = test_next;
    end

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (take)
            res_wr_next = (res_wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
        if (do_pop)
            res_rd_next = (res_rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
        if (take && !do_pop)
            res_cnt_next = res_cnt_reg + 1'b1;
        else if (do_pop && !take)
            res_cnt_next = res_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            fixed_reg   <= 1'b0;
            frame_reg   <= 1'b0;
            mode_reg    <= '0;
            test_reg    <= 1'b0;
            enable_reg  <= 1'b0;
            dim_reg     <= '0;
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
            for (int i = 0; i < RAM_DEPTH; i++)
                ram_reg[i] <= 8'h00;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            fixed_reg   <= fixed_next;
            frame_reg   <= frame_next;
            mode_reg    <= mode_next;
            test_reg    <= test_next;
            enable_reg  <= enable_next;
            dim_reg     <= dim_next;
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
            if (ram_we)
                ram_reg[ptr_reg[RAM_IDX_W-1:0]] <= q_cmd.arg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg[res_wr_reg] <= res_word;
    end

    a_addrset_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_cmd.op == OP_ADDRSET) |=> frame_reg)
        else $error("address command did not open a data frame");

    a_write_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (take && frame_reg && q_cmd.op == OP_DATA))
        else $error("RAM write outside a data frame");

endmodule
